FILE: design/duality_gap_with_rebate_macros.svh
// ----------------------------------------------------------------------------
// Duality gap assertion macros
// Shared concurrent assertion forms for the duality gap block.
// ----------------------------------------------------------------------------
`ifndef DUALITY_GAP_WITH_REBATE_MACROS_SVH
`define DUALITY_GAP_WITH_REBATE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dgr_pkg.sv
// ----------------------------------------------------------------------------
// Duality gap package
// Widths, limits and the request and response of the shared iterative unit.
// ----------------------------------------------------------------------------
package dgr_pkg;

  localparam int unsigned MAX_PATHS = 1048576;
  localparam int unsigned CNT_W     = $clog2(MAX_PATHS + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned VAL_W     = 31;
  localparam int unsigned DIFF_W    = WORD_W + 1;
  localparam int unsigned BAL_W     = 48;
  localparam int unsigned CAND_W    = BAL_W + 2;
  localparam int unsigned VSUM_W    = 52;
  localparam int unsigned SQS_W     = 64;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  localparam int unsigned IU_W      = 64;
  localparam int unsigned IU_CNT_W  = $clog2(IU_W);

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef enum logic {
    IU_DIV  = 1'b0,
    IU_SQRT = 1'b1
  } iu_op_e;

  typedef struct packed {
    logic             start;
    iu_op_e           op;
    logic [IU_W-1:0]  operand;
    logic [CNT_W-1:0] divisor;
  } iu_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [IU_W-1:0] result;
  } iu_rsp_t;

endpackage

FILE: design/dgr_ifs.sv
// ----------------------------------------------------------------------------
// Duality gap channels
// Valid/ready interfaces for step beats in and result beats out.
// ----------------------------------------------------------------------------
interface dgr_step_if import dgr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] payoff;
  logic signed [WORD_W-1:0] continuation_mean;
  logic                     is_exercise_date;
  logic                     exercised;
  logic                     end_of_path;
  logic                     end_of_run;

  modport source (
    output valid, payoff, continuation_mean, is_exercise_date, exercised,
           end_of_path, end_of_run,
    input  ready
  );
  modport sink (
    input  valid, payoff, continuation_mean, is_exercise_date, exercised,
           end_of_path, end_of_run,
    output ready
  );
endinterface

interface dgr_res_if import dgr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [VAL_W-1:0]  path_value;
  logic signed [WORD_W-1:0] mean_gap;
  logic        [VAL_W-1:0]  std_error;
  logic                     is_summary;
  logic                     last;

  modport source (
    output valid, path_value, mean_gap, std_error, is_summary, last,
    input  ready
  );
  modport sink (
    input  valid, path_value, mean_gap, std_error, is_summary, last,
    output ready
  );
endinterface

FILE: design/duality_gap_with_rebate.sv
// ----------------------------------------------------------------------------
// Duality gap with rebate
// Pathwise upper-bound gap per Monte Carlo path, with run mean and standard
// error from saturating running sums.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  step_i   in   one time step: payoff, continuation mean, flags
//  res_o    out  path value, or run summary (mean, standard error)
//
//  Step beat without path end: accept, then update.
//  Path end: update, square, push, plus any wait on res_o.ready.
//  Run end: the shared divide/square-root unit works at one bit per cycle
//  (three divides of 64 quotient bits each, one root of 32 bits).
//  Reset clears balance, maximum, count and sums; no clearing pass.
//  A stalled result holds the sequencer; step_i.ready stays low meanwhile.
// ----------------------------------------------------------------------------
`include "duality_gap_with_rebate_macros.svh"

module duality_gap_with_rebate import dgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dgr_step_if.sink   step_i,
  dgr_res_if.source  res_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_STEP  = 12'b0000_0000_0010,
    ST_SQ    = 12'b0000_0000_0100,
    ST_PATH  = 12'b0000_0000_1000,
    ST_SUMST = 12'b0000_0001_0000,
    ST_DIVM  = 12'b0000_0010_0000,
    ST_DIVS  = 12'b0000_0100_0000,
    ST_MM    = 12'b0000_1000_0000,
    ST_VAR   = 12'b0001_0000_0000,
    ST_DIVV  = 12'b0010_0000_0000,
    ST_SQRT  = 12'b0100_0000_0000,
    ST_SUM   = 12'b1000_0000_0000
  } dgr_state_e;

  dgr_state_e state_q, state_d;

  // item
  logic signed [DIFF_W-1:0] d_q;
  logic                     ex_q, exer_q, eop_q, eor_q;

  // path and run state
  logic signed [BAL_W-1:0]  bal_q, bal_d;
  logic [VAL_W-1:0]         max_q, max_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [VSUM_W-1:0]        vsum_q, vsum_d;
  logic [SQS_W-1:0]         sqs_q, sqs_d;

  // working values
  logic [VAL_W-1:0]         pv_q, pv_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [VAL_W-1:0]         mean_q, mean_d;
  logic [SQS_W-1:0]         msq_q, msq_d;
  logic [VAL_W-1:0]         se_q, se_d;

  // result register
  logic                     ov_q, ov_d;
  logic [VAL_W-1:0]         opv_q, opv_d;
  logic [VAL_W-1:0]         omean_q, omean_d;
  logic [VAL_W-1:0]         ose_q, ose_d;
  logic                     osum_q, osum_d;
  logic                     olast_q, olast_d;

  iu_req_t iu_req;
  iu_rsp_t iu_rsp;

  logic                     accept;
  logic                     out_free;
  logic signed [CAND_W-1:0] bal_x, d_x, cand, bal_sum;
  logic signed [CAND_W-1:0] max_x, valmax_x;
  logic                     use_dmb, do_fold;
  logic [VAL_W-1:0]         new_max;
  logic [VAL_W-1:0]         mul_a;
  logic [VSUM_W:0]          vsum_add;
  logic [SQS_W:0]           sqs_add;
  logic [SQS_W:0]           var_diff;
  logic [SQS_W-1:0]         var_val;
  logic [VAL_W-1:0]         res_clip;

  assign accept   = step_i.valid && step_i.ready;
  assign out_free = !ov_q || res_o.ready;
  assign step_i.ready = (state_q == ST_IDLE);

  // step datapath
  assign bal_x    = {{(CAND_W - BAL_W){bal_q[BAL_W-1]}}, bal_q};
  assign d_x      = {{(CAND_W - DIFF_W){d_q[DIFF_W-1]}}, d_q};
  assign max_x    = $signed({{(CAND_W - VAL_W){1'b0}}, max_q});
  assign valmax_x = $signed({{(CAND_W - VAL_W){1'b0}}, VAL_MAX});
  assign use_dmb  = !eop_q && ex_q && !exer_q;
  assign do_fold  = eop_q || ex_q;
  assign cand     = use_dmb ? (d_x - bal_x) : -bal_x;
  assign bal_sum  = bal_x + d_x;
  assign new_max  = (do_fold && (cand > max_x)) ?
                    ((cand > valmax_x) ? VAL_MAX : cand[VAL_W-1:0]) : max_q;

  assign mul_a    = (state_q == ST_MM) ? mean_q : pv_q;
  assign vsum_add = {1'b0, vsum_q} + (VSUM_W + 1)'(pv_q);
  assign sqs_add  = {1'b0, sqs_q} + (SQS_W + 1)'(prod_q);
  assign var_diff = {1'b0, msq_q} - (SQS_W + 1)'(prod_q);
  assign var_val  = var_diff[SQS_W] ? '0 : var_diff[SQS_W-1:0];
  assign res_clip = (|iu_rsp.result[IU_W-1:VAL_W]) ? VAL_MAX : iu_rsp.result[VAL_W-1:0];

  always_comb begin
    state_d = state_q;
    bal_d   = bal_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    vsum_d  = vsum_q;
    sqs_d   = sqs_q;
    pv_d    = pv_q;
    prod_d  = prod_q;
    mean_d  = mean_q;
    msq_d   = msq_q;
    se_d    = se_q;
    ov_d    = ov_q && !res_o.ready;
    opv_d   = opv_q;
    omean_d = omean_q;
    ose_d   = ose_q;
    osum_d  = osum_q;
    olast_d = olast_q;
    iu_req.start   = 1'b0;
    iu_req.op      = IU_DIV;
    iu_req.operand = '0;
    iu_req.divisor = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (eop_q) begin
          pv_d    = new_max;
          bal_d   = '0;
          max_d   = '0;
          state_d = ST_SQ;
        end else begin
          max_d = new_max;
          if (ex_q && exer_q) begin
            if (bal_sum[CAND_W-1:BAL_W-1] == '0 || bal_sum[CAND_W-1:BAL_W-1] == '1) begin
              bal_d = bal_sum[BAL_W-1:0];
            end else begin
              bal_d = bal_sum[CAND_W-1] ? {1'b1, {(BAL_W - 1){1'b0}}}
                                        : {1'b0, {(BAL_W - 1){1'b1}}};
            end
          end
          state_d = eor_q ? ST_SUMST : ST_IDLE;
        end
      end
      ST_SQ: begin
        prod_d  = PROD_W'(mul_a) * PROD_W'(mul_a);
        state_d = ST_PATH;
      end
      ST_PATH: begin
        if (out_free) begin
          ov_d    = 1'b1;
          opv_d   = pv_q;
          omean_d = '0;
          ose_d   = '0;
          osum_d  = 1'b0;
          olast_d = !eor_q;
          if (cnt_q < CNT_W'(MAX_PATHS)) begin
            cnt_d  = cnt_q + 1'b1;
            vsum_d = vsum_add[VSUM_W] ? '1 : vsum_add[VSUM_W-1:0];
            sqs_d  = sqs_add[SQS_W] ? '1 : sqs_add[SQS_W-1:0];
          end
          state_d = eor_q ? ST_SUMST : ST_IDLE;
        end
      end
      ST_SUMST: begin
        if (cnt_q == '0) begin
          mean_d  = '0;
          se_d    = '0;
          state_d = ST_SUM;
        end else begin
          iu_req.start   = 1'b1;
          iu_req.operand = IU_W'(vsum_q);
          state_d        = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (iu_rsp.done) begin
          mean_d         = res_clip;
          iu_req.start   = 1'b1;
          iu_req.operand = sqs_q;
          state_d        = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (iu_rsp.done) begin
          msq_d   = iu_rsp.result;
          state_d = ST_MM;
        end
      end
      ST_MM: begin
        prod_d  = PROD_W'(mul_a) * PROD_W'(mul_a);
        state_d = ST_VAR;
      end
      ST_VAR: begin
        iu_req.start   = 1'b1;
        iu_req.operand = var_val;
        state_d        = ST_DIVV;
      end
      ST_DIVV: begin
        if (iu_rsp.done) begin
          iu_req.start   = 1'b1;
          iu_req.op      = IU_SQRT;
          iu_req.operand = iu_rsp.result;
          state_d        = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (iu_rsp.done) begin
          se_d    = res_clip;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          ov_d    = 1'b1;
          opv_d   = '0;
          omean_d = mean_q;
          ose_d   = se_q;
          osum_d  = 1'b1;
          olast_d = 1'b1;
          cnt_d   = '0;
          vsum_d  = '0;
          sqs_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dgr_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iu_req),
    .rsp_o  (iu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bal_q   <= '0;
      max_q   <= '0;
      cnt_q   <= '0;
      vsum_q  <= '0;
      sqs_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bal_q   <= bal_d;
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      vsum_q  <= vsum_d;
      sqs_q   <= sqs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_q    <= {step_i.payoff[WORD_W-1], step_i.payoff}
              - {step_i.continuation_mean[WORD_W-1], step_i.continuation_mean};
      ex_q   <= step_i.is_exercise_date;
      exer_q <= step_i.exercised;
      eop_q  <= step_i.end_of_path;
      eor_q  <= step_i.end_of_run;
    end
    pv_q    <= pv_d;
    prod_q  <= prod_d;
    mean_q  <= mean_d;
    msq_q   <= msq_d;
    se_q    <= se_d;
    opv_q   <= opv_d;
    omean_q <= omean_d;
    ose_q   <= ose_d;
    osum_q  <= osum_d;
    olast_q <= olast_d;
  end

  assign res_o.valid      = ov_q;
  assign res_o.path_value = opv_q;
  assign res_o.mean_gap   = $signed({1'b0, omean_q});
  assign res_o.std_error  = ose_q;
  assign res_o.is_summary = osum_q;
  assign res_o.last       = olast_q;

  `DGR_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_PATHS), "path count past limit")
  `DGR_ASSERT_IMP(a_summary_last, clk_i, rst_ni, res_o.valid && res_o.is_summary, res_o.last, "summary beat not last")
  `DGR_ASSERT_NXT(a_path_push, clk_i, rst_ni, state_q == ST_PATH && out_free, res_o.valid && !res_o.is_summary, "path beat not presented")

endmodule

FILE: design/dgr_iter_unit.sv
// ----------------------------------------------------------------------------
// Duality gap iterative unit
// One shared subtract-compare stage: restoring divide, one quotient bit per
// cycle, or digit-by-digit square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`include "duality_gap_with_rebate_macros.svh"

module dgr_iter_unit import dgr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  iu_req_t req_i,
  output iu_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [IU_CNT_W-1:0] cnt_q, cnt_d;
  iu_op_e              op_q;
  logic [IU_W-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [IU_W-1:0]     root_q, root_d;
  logic [IU_W-1:0]     bit_q, bit_d;
  logic [CNT_W-1:0]    div_q;

  logic [CNT_W:0]      shl;
  logic [IU_W-1:0]     sub_a, sub_b;
  logic [IU_W:0]       diff;
  logic                ge;

  assign shl   = {rem_q, acc_q[IU_W-1]};
  assign sub_a = (op_q == IU_DIV) ? IU_W'(shl) : acc_q;
  assign sub_b = (op_q == IU_DIV) ? IU_W'(div_q) : (root_q + bit_q);
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = ~diff[IU_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      unique case (op_q)
        IU_DIV: begin
          rem_d = ge ? diff[CNT_W-1:0] : shl[CNT_W-1:0];
          acc_d = {acc_q[IU_W-2:0], ge};
        end
        IU_SQRT: begin
          acc_d  = ge ? diff[IU_W-1:0] : acc_q;
          root_d = ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
          bit_d  = bit_q >> 2;
        end
        default: ;
      endcase
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = (req_i.op == IU_DIV) ? IU_CNT_W'(IU_W - 1) : IU_CNT_W'(IU_W / 2 - 1);
      acc_d  = req_i.operand;
      rem_d  = '0;
      root_d = '0;
      bit_d  = {2'b01, {(IU_W - 2){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    if (!busy_q && req_i.start) begin
      op_q  <= req_i.op;
      div_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == IU_DIV) ? acc_q : root_q;

  `DGR_ASSERT_IMP(a_no_restart, clk_i, rst_ni, req_i.start, !busy_q, "start while busy")
  `DGR_ASSERT_NXT(a_done_follows, clk_i, rst_ni, busy_q && cnt_q == '0, done_q && !busy_q, "done missing after last step")
  `DGR_ASSERT_IMP(a_rem_range, clk_i, rst_ni, busy_q && op_q == IU_DIV, rem_q < div_q, "remainder not below divisor")

endmodule
